@@ hdl/seven_segment_mux_display_core_assert.svh @@
// Assertion macros for the seven-segment display core.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_CORE_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define SSMD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SSMD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ssmd_pkg.sv @@
// Shared types, command codes and the glyph table for the display core.
// No dependencies.
package ssmd_pkg;

  localparam int unsigned DIGITS_DEF    = 3;
  localparam int unsigned MAX_VALUE_DEF = 999;

  // Decimal point bit in the ED.C GBFA segment map
  localparam logic [7:0] DP_BIT = 8'h20;

  // ASCII offsets
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_UP_A   = 8'h41;
  localparam logic [7:0] ASCII_UP_Z   = 8'h5a;
  localparam logic [7:0] ASCII_LO_A   = 8'h61;
  localparam logic [7:0] ASCII_LO_Z   = 8'h7a;
  localparam logic [7:0] UPPER_OFFSET = 8'd55;
  localparam logic [7:0] LOWER_OFFSET = 8'd87;

  localparam int unsigned GLYPH_COUNT = 36;

  localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
    8'hd7, 8'h14, 8'hcd, 8'h5d, 8'h1e, 8'h5b, 8'hdb, 8'h15, 8'hdf, 8'h5f,
    8'h9f, 8'hda, 8'hc3, 8'hdc, 8'hcb, 8'h8b, 8'hd3, 8'h9e, 8'h82, 8'hd4,
    8'h00, 8'hc2, 8'h00, 8'h97, 8'hd7, 8'h8f, 8'h1f, 8'h88, 8'h5b, 8'hca,
    8'hd6, 8'h00, 8'h00, 8'h00, 8'h5e, 8'h00
  };

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_TEXT   = 2'd2
  } ssmd_cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] number;
    logic [7:0]         decimal_position;
    logic [7:0]         text_char;
    logic               text_first;
  } ssmd_in_t;

  typedef struct packed {
    logic [7:0]  segments;
    logic [2:0]  digit_select;
    logic [31:0] millisecond_count;
  } ssmd_out_t;

  // Decoded controls for the state update of one item
  typedef struct packed {
    logic fire;
    logic is_tick;
    logic is_number;
    logic number_ok;
    logic is_text;
    logic text_first;
    logic text_nul;
  } ssmd_ctrl_t;

  function automatic logic [7:0] glyph_lookup(input logic [5:0] idx);
    logic [7:0] pat;
    pat = 8'h00;
    if (32'(idx) < GLYPH_COUNT) begin
      pat = GLYPHS[idx];
    end
    return pat;
  endfunction

endpackage

@@ hdl/ssmd_num_conv.sv @@
// Number to segment patterns: range check, decimal split, blanking, point.
// Depends on ssmd_pkg.
module ssmd_num_conv import ssmd_pkg::*; #(
  parameter int unsigned DIGITS    = DIGITS_DEF,
  parameter int unsigned MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic signed [15:0]        number_i,
  input  logic [7:0]                decimal_position_i,
  output logic                      number_ok_o,
  output logic [DIGITS-1:0][7:0]    patterns_o
);

  logic [14:0] value;
  logic [14:0] quot [DIGITS+1];

  assign value       = number_i[14:0];
  assign number_ok_o = !number_i[15] && (value <= 15'(MAX_VALUE));

  // value / 10^k by reciprocal multiply, exact for 15-bit values
  assign quot[0] = value;
  for (genvar k = 1; k <= DIGITS; k++) begin : g_quot
    localparam int unsigned POW = 10 ** k;
    localparam int unsigned SH  = 15 + $clog2(POW);
    localparam longint unsigned RECIP = (64'd1 << SH) / POW + 64'd1;
    localparam logic [16:0] RW = 17'(RECIP);
    logic [31:0] prod;
    assign prod    = {17'd0, value} * {15'd0, RW};
    assign quot[k] = 15'(prod >> SH);
  end

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    logic [14:0] tens;
    logic [3:0]  dgt;
    logic [7:0]  pat;
    logic        shown;
    assign tens  = (quot[k+1] << 3) + (quot[k+1] << 1);
    assign dgt   = 4'(quot[k] - tens);
    assign shown = (k == 0) || (quot[k] != 15'd0);
    always_comb begin
      pat = shown ? glyph_lookup({2'b00, dgt}) : 8'h00;
      if ((decimal_position_i != 8'd0) && (decimal_position_i == 8'(k))) begin
        pat = pat | DP_BIT;
      end else begin
        pat = pat & ~DP_BIT;
      end
    end
    assign patterns_o[k] = pat;
  end

endmodule

@@ hdl/ssmd_char_map.sv @@
// ASCII character to segment pattern through the glyph table.
// Depends on ssmd_pkg.
module ssmd_char_map import ssmd_pkg::*; (
  input  logic [7:0] text_char_i,
  output logic [7:0] pattern_o
);

  logic [7:0] offs;

  always_comb begin
    offs      = 8'd0;
    pattern_o = 8'h00;
    if (text_char_i >= ASCII_ZERO && text_char_i <= ASCII_NINE) begin
      offs      = text_char_i - ASCII_ZERO;
      pattern_o = glyph_lookup(offs[5:0]);
    end else if (text_char_i >= ASCII_UP_A && text_char_i <= ASCII_UP_Z) begin
      offs      = text_char_i - UPPER_OFFSET;
      pattern_o = glyph_lookup(offs[5:0]);
    end else if (text_char_i >= ASCII_LO_A && text_char_i <= ASCII_LO_Z) begin
      offs      = text_char_i - LOWER_OFFSET;
      pattern_o = glyph_lookup(offs[5:0]);
    end
  end

endmodule

@@ hdl/ssmd_state.sv @@
// Digit store, scan pointer, text pointer and millisecond counter.
// Depends on ssmd_pkg and the assertion macro header.
`include "seven_segment_mux_display_core_assert.svh"

module ssmd_state import ssmd_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssmd_ctrl_t             ctrl_i,
  input  logic [DIGITS-1:0][7:0] num_patterns_i,
  input  logic [7:0]             char_pattern_i,
  output ssmd_out_t              result_o
);

  localparam int unsigned SW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned TPW = $clog2(DIGITS + 1);

  logic [7:0]     store_q [DIGITS];
  logic [7:0]     store_d [DIGITS];
  logic [SW-1:0]  scan_q, scan_d;
  logic [TPW-1:0] text_q, text_d;
  logic [31:0]    tick_q, tick_d;

  logic [TPW-1:0] text_eff;
  logic [SW-1:0]  text_idx;
  logic [2:0]     sel;

  assign text_eff = ctrl_i.text_first ? '0 : text_q;
  // leftmost position first
  assign text_idx = SW'(DIGITS - 1 - 32'(text_eff));

  always_comb begin
    store_d = store_q;
    text_d  = text_q;
    scan_d  = scan_q;
    tick_d  = tick_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.is_number && ctrl_i.number_ok) begin
        for (int i = 0; i < DIGITS; i++) begin
          store_d[i] = num_patterns_i[i];
        end
      end
      if (ctrl_i.is_text) begin
        text_d = text_eff;
        if (!ctrl_i.text_nul && (32'(text_eff) < DIGITS)) begin
          store_d[text_idx] = char_pattern_i;
          text_d            = text_eff + TPW'(1);
        end
      end
      if (ctrl_i.is_tick) begin
        tick_d = tick_q + 32'd1;
        scan_d = (32'(scan_q) == DIGITS - 1) ? '0 : scan_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        store_q[i] <= 8'h00;
      end
      scan_q <= '0;
      text_q <= '0;
      tick_q <= 32'd0;
    end else begin
      store_q <= store_d;
      scan_q  <= scan_d;
      text_q  <= text_d;
      tick_q  <= tick_d;
    end
  end

  // active-low select; scan positions beyond the three select lines read all ones
  always_comb begin
    sel = 3'b111;
    if (32'(scan_q) < 32'd3) begin
      sel = ~(3'b001 << scan_q);
    end
  end

  assign result_o.segments          = store_q[scan_q];
  assign result_o.digit_select      = sel;
  assign result_o.millisecond_count = tick_q + 32'd1;

  `SSMD_ASSERT(a_tick_step, clk_i, rst_ni, ctrl_i.fire && ctrl_i.is_tick |=> tick_q == $past(tick_q) + 32'd1, "counter did not advance on tick")
  `SSMD_ASSERT(a_scan_range, clk_i, rst_ni, 32'(scan_q) < DIGITS, "scan position out of range")
  `SSMD_ASSERT(a_text_range, clk_i, rst_ni, 32'(text_q) <= DIGITS, "text position past digit count")

endmodule

@@ hdl/seven_segment_mux_display_core.sv @@
// Top level of the multiplexed seven-segment display core.
// Depends on ssmd_pkg, ssmd_num_conv, ssmd_char_map, ssmd_state, assertion macros.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | into core | in_valid_i / in_stall_o   | in_i  (ssmd_in_t)
//  out     | from core | out_valid_o / out_stall_i | out_o (ssmd_out_t)
//
// One beat per cycle while the output is not stalled: a beat is registered on
// entry, applied to the state as it leaves the input register, and a tick's
// result is registered in the output register on that same edge; writes give none.
// Reset clears the digit store (blank), scan and text pointers and the counter.
// A stalled output holds the input register; in_stall_o rises only when an
// item waits there and the output register is full and stalled.
`include "seven_segment_mux_display_core_assert.svh"

module seven_segment_mux_display_core import ssmd_pkg::*; #(
  parameter int unsigned DIGITS    = DIGITS_DEF,
  parameter int unsigned MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ssmd_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssmd_out_t out_o
);

  logic      in_valid_q;
  ssmd_in_t  in_q;
  logic      out_valid_q;
  ssmd_out_t out_q;

  logic       advance;
  ssmd_ctrl_t ctrl;
  ssmd_out_t  result;

  logic                   number_ok;
  logic [DIGITS-1:0][7:0] num_patterns;
  logic [7:0]             char_pattern;

  // the held item moves on whenever the output slot is free or being emptied
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  // decode
  assign ctrl.fire       = in_valid_q && advance;
  assign ctrl.is_tick    = (in_q.cmd == CMD_TICK);
  assign ctrl.is_number  = (in_q.cmd == CMD_NUMBER);
  assign ctrl.number_ok  = number_ok;
  assign ctrl.is_text    = (in_q.cmd == CMD_TEXT);
  assign ctrl.text_first = in_q.text_first;
  assign ctrl.text_nul   = (in_q.text_char == 8'h00);

  ssmd_num_conv #(
    .DIGITS    (DIGITS),
    .MAX_VALUE (MAX_VALUE)
  ) u_num_conv (
    .number_i           (in_q.number),
    .decimal_position_i (in_q.decimal_position),
    .number_ok_o        (number_ok),
    .patterns_o         (num_patterns)
  );

  ssmd_char_map u_char_map (
    .text_char_i (in_q.text_char),
    .pattern_o   (char_pattern)
  );

  ssmd_state #(
    .DIGITS (DIGITS)
  ) u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .num_patterns_i (num_patterns),
    .char_pattern_i (char_pattern),
    .result_o       (result)
  );

  // output register: only ticks make a beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ctrl.fire && ctrl.is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire && ctrl.is_tick) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SSMD_ASSERT(a_write_no_beat, clk_i, rst_ni, ctrl.fire && !ctrl.is_tick |=> !out_valid_o, "write item produced an output beat")
  `SSMD_ASSERT(a_select_onecold, clk_i, rst_ni, out_valid_o |-> $countones(~out_o.digit_select) <= 1, "more than one digit selected")
  `SSMD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !in_stall_o, "stall raised during reset")

endmodule

@@ tb/tb_seven_segment_mux_display_core.sv @@
// Self-checking testbench for seven_segment_mux_display_core. It sends ticks, number writes and
// text writes with random gaps and output stalls, and checks every scan beat against a model.
// Depends on ssmd_pkg and the core RTL.
module tb_seven_segment_mux_display_core;
  import ssmd_pkg::*;

  localparam int unsigned NUM_DIGITS   = DIGITS_DEF;
  localparam int          TOP_VALUE    = MAX_VALUE_DEF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;     // not decoded by the core
  localparam logic [7:0]  POINT_SEG    = 8'h20;    // decimal point in the ED.C GBFA map
  localparam int          STALL_LIMIT  = 2000;     // cycles with no beat moving
  localparam int          HOLD_CYCLES  = 200;      // long output hold-off
  localparam int          TAIL_CYCLES  = 8;        // pipeline is two deep, so plenty
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          BURST_ITEMS  = 300;
  localparam int          HOLD_TICKS   = 40;

  // Segment font: digits 0-9 then letters A-Z
  localparam logic [7:0] FONT [36] = '{
    8'hd7, 8'h14, 8'hcd, 8'h5d, 8'h1e, 8'h5b, 8'hdb, 8'h15, 8'hdf, 8'h5f,
    8'h9f, 8'hda, 8'hc3, 8'hdc, 8'hcb, 8'h8b, 8'hd3, 8'h9e, 8'h82, 8'hd4,
    8'h00, 8'hc2, 8'h00, 8'h97, 8'hd7, 8'h8f, 8'h1f, 8'h88, 8'h5b, 8'hca,
    8'hd6, 8'h00, 8'h00, 8'h00, 8'h5e, 8'h00
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  ssmd_in_t  in_beat   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ssmd_out_t out_data;

  // Display model: digit store, scan and text pointers, tick counter
  logic [7:0]  shown [NUM_DIGITS] = '{default: 8'h00};
  int unsigned scan_idx   = 0;
  int unsigned text_idx   = 0;
  logic [31:0] tick_count = '0;
  ssmd_out_t   expected_scans [$];

  int errors         = 0;
  int beats_sent     = 0;
  int scans_checked  = 0;
  int writes_ignored = 0;

  // Idling knobs; hold_output is driven only by the hold-off process
  bit   sender_idles   = 1'b1;
  bit   receiver_idles = 1'b1;
  logic hold_output    = 1'b0;

  seven_segment_mux_display_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Digits and letters of either case map through the font; anything else is blank.
  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] pat;
    pat = 8'h00;
    if (c >= "0" && c <= "9") begin
      pat = FONT[c - "0"];
    end else if (c >= "A" && c <= "Z") begin
      pat = FONT[c - "A" + 10];
    end else if (c >= "a" && c <= "z") begin
      pat = FONT[c - "a" + 10];
    end
    return pat;
  endfunction

  // Applies one accepted beat to the model; a tick queues the scan beat it should give.
  function automatic void predict_display(input ssmd_in_t item);
    int         value;
    int         ndig;
    int         q;
    int         pos;
    logic [7:0] pat;
    ssmd_out_t  scan;
    case (item.cmd)
      CMD_NUMBER: begin
        value = $signed(item.number);
        if (value < 0 || value > TOP_VALUE) begin
          writes_ignored++;   // store left alone
        end else begin
          ndig = 1;
          for (q = value; q >= 10; q /= 10) ndig++;
          // right-aligned, leading positions blank; point only where asked, never at 0
          for (pos = 0; pos < NUM_DIGITS; pos++) begin
            pat = (pos < ndig) ? FONT[value % 10] : 8'h00;
            value /= 10;
            if (item.decimal_position != 0 && item.decimal_position == pos) begin
              pat |= POINT_SEG;
            end else begin
              pat &= ~POINT_SEG;
            end
            shown[pos] = pat;
          end
        end
      end
      CMD_TEXT: begin
        // restart still applies to a NUL; NUL itself writes nothing
        if (item.text_first) text_idx = 0;
        if (item.text_char != 8'h00 && text_idx < NUM_DIGITS) begin
          shown[NUM_DIGITS - 1 - text_idx] = glyph_of(item.text_char);
          text_idx++;
        end
      end
      CMD_TICK: begin
        tick_count++;
        if (scan_idx >= NUM_DIGITS) scan_idx = 0;
        scan.segments          = shown[scan_idx];
        scan.digit_select      = (scan_idx < 3) ? 3'(~(32'd1 << scan_idx)) : 3'b111;
        scan.millisecond_count = tick_count;
        expected_scans.push_back(scan);
        scan_idx = (scan_idx + 1 >= NUM_DIGITS) ? 0 : scan_idx + 1;
      end
      default: begin
        // unused command: no effect, no beat
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic ssmd_in_t make_item(input logic [1:0] cmd, input int number,
                                         input int dp, input int ch, input bit first);
    ssmd_in_t item;
    item.cmd              = cmd;
    item.number           = 16'(number);
    item.decimal_position = 8'(dp);
    item.text_char        = 8'(ch);
    item.text_first       = first;
    return item;
  endfunction

  function automatic logic [7:0] random_alnum();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 61);
    if (r < 10) begin
      c = 8'("0" + r);
    end else if (r < 36) begin
      c = 8'("A" + r - 10);
    end else begin
      c = 8'("a" + r - 36);
    end
    return c;
  endfunction

  // Unused fields stay random so that every payload bit toggles.
  function automatic ssmd_in_t random_item();
    ssmd_in_t item;
    int       pick;
    item.number           = 16'($urandom);
    item.decimal_position = 8'($urandom);
    item.text_char        = 8'($urandom);
    item.text_first       = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      item.cmd = CMD_TICK;
    end else if (pick < 70) begin
      item.cmd = CMD_NUMBER;
      // mostly displayable values; the rest stays raw 16-bit, half negative
      if ($urandom_range(0, 9) < 7) item.number = 16'($urandom_range(0, TOP_VALUE));
      if ($urandom_range(0, 3) != 0) item.decimal_position = 8'($urandom_range(0, NUM_DIGITS));
    end else if (pick < 95) begin
      item.cmd = CMD_TEXT;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        item.text_char = random_alnum();
      end else if (pick == 7) begin
        item.text_char = 8'h00;
      end
      item.text_first = ($urandom_range(0, 3) == 0);
    end else begin
      item.cmd = CMD_UNUSED;
    end
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Optional idle gap, then offer the beat and hold it until the core takes it.
  task automatic send_beat(input ssmd_in_t item);
    int gap;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= item;
    do @(posedge clk); while (in_stall);
    predict_display(item);
    beats_sent++;
  endtask

  // Sender goes quiet until every queued scan beat has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command and the awkward corners.
  task automatic test_directed_cases();
    repeat (3) send_beat(make_item(CMD_TICK, 0, 0, 0, 0));   // blank store, each select
    send_beat(make_item(CMD_NUMBER, 0, 0, 0, 0));            // zero, no point
    send_beat(make_item(CMD_NUMBER, TOP_VALUE, 2, 0, 0));    // full width, point on left digit
    send_beat(make_item(CMD_NUMBER, -1, 1, 0, 0));           // negative: dropped
    send_beat(make_item(CMD_NUMBER, TOP_VALUE + 1, 1, 0, 0));// too large: dropped
    send_beat(make_item(CMD_NUMBER, -32768, 255, 255, 1));   // most negative
    send_beat(make_item(CMD_NUMBER, 32767, 0, 0, 0));        // most positive
    repeat (3) send_beat(make_item(CMD_TICK, 0, 0, 0, 0));
    send_beat(make_item(CMD_NUMBER, 5, 1, 0, 0));            // point on a blank position
    send_beat(make_item(CMD_NUMBER, 42, 255, 0, 0));         // point beyond the display
    send_beat(make_item(CMD_TEXT, 0, 0, "A", 1));
    send_beat(make_item(CMD_TEXT, 0, 0, "z", 0));
    send_beat(make_item(CMD_TEXT, 0, 0, "9", 0));
    send_beat(make_item(CMD_TEXT, 0, 0, "#", 0));            // past the last digit: dropped
    send_beat(make_item(CMD_TICK, 0, 0, 0, 0));
    send_beat(make_item(CMD_TEXT, 0, 0, 255, 1));            // unmapped char gives blank
    send_beat(make_item(CMD_TEXT, 0, 0, 0, 1));              // NUL still restarts the string
    send_beat(make_item(CMD_TEXT, 0, 0, "q", 0));            // so this lands leftmost again
    send_beat(make_item(CMD_UNUSED, -1, 255, 255, 1));       // ignored, no beat
    repeat (3) send_beat(make_item(CMD_TICK, -1, 255, 255, 1));
  endtask

  // Mixed traffic, a quarter of it well-formed strings each followed by a full scan.
  task automatic test_random_traffic(input int count);
    int start;
    int len;
    int k;
    start = beats_sent;
    while (beats_sent - start < count) begin
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, NUM_DIGITS + 2);
        for (k = 0; k < len; k++) begin
          send_beat(make_item(CMD_TEXT, $urandom, $urandom, int'(random_alnum()), k == 0));
        end
        if ($urandom_range(0, 1)) send_beat(make_item(CMD_TEXT, $urandom, $urandom, 0, 0));
        repeat (NUM_DIGITS) begin
          send_beat(make_item(CMD_TICK, $urandom, $urandom, $urandom,
                              1'($urandom_range(0, 1))));
        end
      end else begin
        send_beat(random_item());
      end
    end
  endtask

  // Both sides flat out: no gaps, no stalls.
  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_traffic(BURST_ITEMS);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so the core
  // fills and must stall its input; then everything has to drain in order.
  task automatic test_output_backpressure();
    wait_drained();
    sender_idles = 1'b0;
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
      end
    join_none
    repeat (HOLD_TICKS) begin
      send_beat(make_item(CMD_TICK, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1))));
    end
    sender_idles = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare each scan beat, then draw the next stall
  // ---------------------------------------------------------------------------

  initial begin : scan_checker
    int        stall_left;
    ssmd_out_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_scans.size() == 0) begin
          errors++;
          $error("scan beat with nothing expected: %h", out_data);
        end else begin
          want = expected_scans.pop_front();
          scans_checked++;
          if (out_data.segments !== want.segments) begin
            errors++;
            $error("segments: expected %h, got %h", want.segments, out_data.segments);
          end
          if (out_data.digit_select !== want.digit_select) begin
            errors++;
            $error("digit_select: expected %b, got %b",
                   want.digit_select, out_data.digit_select);
          end
          if (out_data.millisecond_count !== want.millisecond_count) begin
            errors++;
            $error("millisecond_count: expected %0d, got %0d",
                   want.millisecond_count, out_data.millisecond_count);
          end
        end
        stall_left = receiver_idles ? $urandom_range(0, 12) : 0;
      end
      out_stall <= hold_output || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    wait_drained();
    test_random_traffic(RANDOM_ITEMS);
    test_back_to_back();
    test_output_backpressure();
    wait_drained();

    $display("Covered %0d input beats: ticks, number and text writes, NULs, unused commands",
             beats_sent);
    $display("%0d scan beats checked, %0d out-of-range numbers dropped, %0d mismatches",
             scans_checked, writes_ignored, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ssmd_pkg.sv
hdl/ssmd_num_conv.sv
hdl/ssmd_char_map.sv
hdl/ssmd_state.sv
hdl/seven_segment_mux_display_core.sv
tb/tb_seven_segment_mux_display_core.sv
